>>> src/assert_macros.svh
// Assertion macros used by the checker file of the echo core.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication; cons may carry further ## delays.
`define SFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error(msg);

`endif

>>> src/sfd_pkg.sv
// Shared types, widths, register codes and the saturating helper of the echo core.
// No dependencies.
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int MAX_DELAY = 262144;
  localparam int POS_W     = $clog2(MAX_DELAY);
  localparam int FILL_W    = $clog2(MAX_DELAY + 1);
  localparam int SAMPLE_W  = 24;
  localparam int GAIN_W    = 17;
  localparam int GAIN_FRAC = 16;
  localparam int LEN_W     = 19;
  localparam int CFG_W     = 19;
  localparam int IDX_W     = 2;
  localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
  localparam int SCALED_W  = PROD_W - GAIN_FRAC;
  localparam int SUM_W     = SCALED_W + 1;

  // register indexes
  localparam logic [IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [IDX_W-1:0] CFG_GAIN   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_LENGTH = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(13107);
  localparam logic [POS_W-1:0]  LIM_RESET  = POS_W'(12000 - 1);

  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  typedef struct packed {
    logic             we;      // enabled beat taken: write slot at waddr
    logic [POS_W-1:0] waddr;
    logic             re;      // fetch next slot from the store
    logic [POS_W-1:0] raddr;
    logic             len1;    // one-slot delay: next slot is the one just written
    logic             rd_hit;  // next slot written since the last clear
    logic             clear;   // length written: store reads as zero again
  } lane_ctrl_t;

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end else begin
      r = v;
    end
    return $signed(r[SAMPLE_W-1:0]);
  endfunction

endpackage

>>> src/sfd_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/sfd_lane.sv
// One channel of the echo: its delay store, the fetched-slot bypass and the gain unit.
// Depends on sfd_pkg and sfd_ram.
`timescale 1ns / 1ps

module sfd_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sfd_pkg::lane_ctrl_t               ctrl_i,
  input  logic [sfd_pkg::GAIN_W-1:0]        gain_i,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                              silent_i,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] held_i,
  output logic signed [sfd_pkg::SAMPLE_W-1:0] out_o
);

  logic [sfd_pkg::SAMPLE_W-1:0]        rdata;
  logic signed [sfd_pkg::SAMPLE_W-1:0] head_d, head_q;
  logic                                src_d, src_q;
  logic signed [sfd_pkg::SAMPLE_W-1:0] cur;
  logic signed [sfd_pkg::GAIN_W:0]     gain_s;
  logic signed [sfd_pkg::PROD_W-1:0]   prod, rounded;
  logic signed [sfd_pkg::SCALED_W-1:0] scaled;
  logic signed [sfd_pkg::SAMPLE_W-1:0] add_s;
  logic signed [sfd_pkg::SUM_W-1:0]    wr_sum, out_sum;
  logic signed [sfd_pkg::SAMPLE_W-1:0] wr_val;

  localparam logic signed [sfd_pkg::PROD_W-1:0] ROUND =
    sfd_pkg::PROD_W'(64'sd1 <<< (sfd_pkg::GAIN_FRAC - 1));

  sfd_ram #(
    .WIDTH (sfd_pkg::SAMPLE_W),
    .DEPTH (sfd_pkg::MAX_DELAY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.we),
    .waddr_i (ctrl_i.waddr),
    .wdata_i (wr_val),
    .re_i    (ctrl_i.re),
    .raddr_i (ctrl_i.raddr),
    .rdata_o (rdata)
  );

  // content of the slot at the current position
  assign cur    = src_q ? $signed(rdata) : head_q;
  assign gain_s = $signed({1'b0, gain_i});
  assign prod   = cur * gain_s;
  assign rounded = prod + ROUND;
  // floor division of the rounded product by 2^GAIN_FRAC: round to nearest, ties up
  assign scaled = $signed(rounded[sfd_pkg::PROD_W-1:sfd_pkg::GAIN_FRAC]);

  assign add_s   = silent_i ? '0 : sample_i;
  assign wr_sum  = scaled + add_s;
  assign wr_val  = sfd_pkg::sat_sample(wr_sum);
  assign out_sum = scaled + held_i;
  assign out_o   = sfd_pkg::sat_sample(out_sum);

  always_comb begin
    head_d = head_q;
    src_d  = src_q;
    if (ctrl_i.clear) begin
      head_d = '0;
      src_d  = 1'b0;
    end else if (ctrl_i.we) begin
      if (ctrl_i.len1) begin
        head_d = wr_val;
        src_d  = 1'b0;
      end else if (ctrl_i.rd_hit) begin
        src_d  = 1'b1;
      end else begin
        head_d = '0;
        src_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      src_q  <= 1'b0;
    end else begin
      head_q <= head_d;
      src_q  <= src_d;
    end
  end

endmodule

>>> src/stereo_feedback_delay_core.sv
// Stereo feedback delay: top level with position control, result stage and output register.
// Depends on sfd_pkg and sfd_lane (which holds sfd_ram).
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid_i / in_ready_o) takes one stereo beat: two Q1.23
//   samples, a silent flag and a block-end mark.
// - Output channel (out_valid_o / out_ready_i) returns one beat per input beat,
//   in order: both channels plus the echo, saturated, and the block-end mark.
// - Config port: cfg_we_i with cfg_idx_i 0 enable, 1 feedback gain (Q1.16),
//   2 delay length. Write only while no beat is in flight. A length write
//   empties the echo store at once (a fill count, no clearing sweep).
// - Path: a taken beat goes through the result stage, then the output register.
// - Throughput: one beat per cycle while the receiver keeps up, set by the per-channel
//   store, which per beat does one write (current slot) and at most one read (next slot).
// - Each channel has its own lane: store, one 24x18 multiplier, three adders (rounding, feedback, output).
//   The single scaled slot value serves both the feedback of the new beat and
//   the output of the beat before it.
// - When the receiver stalls, the output register holds and the result stage
//   keeps its finished beat; input is refused only while both are full.
// - Reset: enable off, gain 13107, length 12000, store empty, position zero.
// - Disabled: beats pass unchanged and the store does not move.

module stereo_feedback_delay_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sfd_pkg::IDX_W-1:0]           cfg_idx_i,
  input  logic [sfd_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] left_in_i,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] right_in_i,
  input  logic                                silent_i,
  input  logic                                last_in_block_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [sfd_pkg::SAMPLE_W-1:0] left_out_o,
  output logic signed [sfd_pkg::SAMPLE_W-1:0] right_out_o,
  output logic                                block_end_o
);

  // configuration
  logic                         enable_q;
  logic [sfd_pkg::GAIN_W-1:0]   gain_q;
  logic [sfd_pkg::POS_W-1:0]    lim_q;      // effective length minus one
  logic [sfd_pkg::POS_W-1:0]    lim_d;
  logic                         clear;

  // position and fill count
  logic [sfd_pkg::POS_W-1:0]    pos_d, pos_q, next_pos;
  logic [sfd_pkg::FILL_W-1:0]   fill_d, fill_q;

  // handshake
  logic                         fire, fire_en;
  logic                         s1_move;

  // result stage: beat waiting for its echo, or finished (done)
  logic                                s1_valid_d, s1_valid_q;
  logic                                s1_done_d, s1_done_q;
  logic signed [sfd_pkg::SAMPLE_W-1:0] s1_left_d, s1_left_q;
  logic signed [sfd_pkg::SAMPLE_W-1:0] s1_right_d, s1_right_q;
  logic                                s1_last_d, s1_last_q;
  logic signed [sfd_pkg::SAMPLE_W-1:0] lane_left, lane_right;
  logic signed [sfd_pkg::SAMPLE_W-1:0] res_left, res_right;

  // output register
  logic                                out_valid_d, out_valid_q;
  logic signed [sfd_pkg::SAMPLE_W-1:0] out_left_q, out_right_q;
  logic                                out_last_q;

  sfd_pkg::lane_ctrl_t                 ctrl;

  // ---------------------------------------------------------------
  // Config writes; length is clamped to 1..MAX_DELAY on the way in
  // ---------------------------------------------------------------
  assign clear = cfg_we_i && (cfg_idx_i == sfd_pkg::CFG_LENGTH);

  always_comb begin
    if (cfg_wdata_i[sfd_pkg::LEN_W-1:0] == '0) begin
      lim_d = '0;
    end else if (cfg_wdata_i[sfd_pkg::LEN_W-1:0] > sfd_pkg::LEN_W'(sfd_pkg::MAX_DELAY)) begin
      lim_d = sfd_pkg::POS_W'(sfd_pkg::MAX_DELAY - 1);
    end else begin
      lim_d = sfd_pkg::POS_W'(cfg_wdata_i[sfd_pkg::LEN_W-1:0] - sfd_pkg::LEN_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      gain_q   <= sfd_pkg::GAIN_RESET;
      lim_q    <= sfd_pkg::LIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfd_pkg::CFG_ENABLE: enable_q <= cfg_wdata_i[0];
        sfd_pkg::CFG_GAIN:   gain_q   <= cfg_wdata_i[sfd_pkg::GAIN_W-1:0];
        sfd_pkg::CFG_LENGTH: lim_q    <= lim_d;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------
  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign fire       = in_valid_i && in_ready_o;
  assign fire_en    = fire && enable_q;

  // ---------------------------------------------------------------
  // Circular position; slots at or above the fill count read as zero
  // ---------------------------------------------------------------
  assign next_pos = (pos_q == lim_q) ? '0 : pos_q + sfd_pkg::POS_W'(1);

  always_comb begin
    pos_d  = pos_q;
    fill_d = fill_q;
    if (clear) begin
      pos_d  = '0;
      fill_d = '0;
    end else if (fire_en) begin
      pos_d = next_pos;
      if ({1'b0, pos_q} == fill_q) begin
        fill_d = fill_q + sfd_pkg::FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fill_q <= '0;
    end else begin
      pos_q  <= pos_d;
      fill_q <= fill_d;
    end
  end

  always_comb begin
    ctrl.we     = fire_en;
    ctrl.waddr  = pos_q;
    ctrl.len1   = (lim_q == '0);
    ctrl.rd_hit = ({1'b0, next_pos} < fill_q);
    ctrl.re     = fire_en && !ctrl.len1 && ctrl.rd_hit;
    ctrl.raddr  = next_pos;
    ctrl.clear  = clear;
  end

  // ---------------------------------------------------------------
  // Lanes
  // ---------------------------------------------------------------
  sfd_lane u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .gain_i   (gain_q),
    .sample_i (left_in_i),
    .silent_i (silent_i),
    .held_i   (s1_left_q),
    .out_o    (lane_left)
  );

  sfd_lane u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .gain_i   (gain_q),
    .sample_i (right_in_i),
    .silent_i (silent_i),
    .held_i   (s1_right_q),
    .out_o    (lane_right)
  );

  // ---------------------------------------------------------------
  // Result stage: the echo is ready the cycle after the beat is taken;
  // if the output is stalled the finished value is kept here.
  // ---------------------------------------------------------------
  assign res_left  = s1_done_q ? s1_left_q  : lane_left;
  assign res_right = s1_done_q ? s1_right_q : lane_right;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_done_d  = s1_done_q;
    s1_left_d  = s1_left_q;
    s1_right_d = s1_right_q;
    s1_last_d  = s1_last_q;
    priority if (fire) begin
      s1_valid_d = 1'b1;
      s1_done_d  = !enable_q;      // pass-through beats are finished already
      s1_left_d  = left_in_i;
      s1_right_d = right_in_i;
      s1_last_d  = last_in_block_i;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end else if (s1_valid_q) begin
      s1_done_d  = 1'b1;
      s1_left_d  = res_left;
      s1_right_d = res_right;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_done_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_done_q  <= s1_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_left_q  <= s1_left_d;
    s1_right_q <= s1_right_d;
    s1_last_q  <= s1_last_d;
  end

  // ---------------------------------------------------------------
  // Output register: merges both lanes and the block-end mark
  // ---------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_left_q  <= res_left;
      out_right_q <= res_right;
      out_last_q  <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_left_q;
  assign right_out_o = out_right_q;
  assign block_end_o = out_last_q;

endmodule

>>> src/sfd_checker.sv
// Port-level checks for the echo core, bound to its top level.
// Depends on sfd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_we_i,
  input logic [sfd_pkg::IDX_W-1:0]           cfg_idx_i,
  input logic [sfd_pkg::CFG_W-1:0]           cfg_wdata_i,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic signed [sfd_pkg::SAMPLE_W-1:0] left_in_i,
  input logic signed [sfd_pkg::SAMPLE_W-1:0] right_in_i,
  input logic                                silent_i,
  input logic                                last_in_block_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [sfd_pkg::SAMPLE_W-1:0] left_out_o,
  input logic signed [sfd_pkg::SAMPLE_W-1:0] right_out_o,
  input logic                                block_end_o
);

  // stalled output beat holds
  `SFD_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
    (out_valid_o && $stable(left_out_o) && $stable(right_out_o) && $stable(block_end_o)),
    "output beat changed while stalled")

  // input is refused only when the output side is backed up
  `SFD_ASSERT_IMP(a_stall_cause, !in_ready_o, out_valid_o && !out_ready_i,
    "input refused without an output stall")

  // a taken beat shows as a valid output after the result stage and output register
  `SFD_ASSERT_NXT(a_latency, in_valid_i && in_ready_o, ##1 out_valid_o,
    "no output beat two cycles after an input beat")

endmodule

bind stereo_feedback_delay_core sfd_checker u_sfd_checker (.*);

>>> test/tb_top.sv
// Self-checking bench for stereo_feedback_delay_core: directed table, then random phases.
// Depends on sfd_pkg and the core RTL; holds its own echo predictor.
`timescale 1ns / 1ps

module tb_top;

  // index 3 has no register behind it; writes there must be dropped
  localparam logic [sfd_pkg::IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off, forces input stall
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no beat moving anywhere
  localparam int SETTLE_CYCLES  = 6;     // covers the result stage and output register, with a little margin
  localparam int N_PHASES       = 13;
  localparam int PHASE_BEATS    = 150;
  localparam int SLOW_PCT       = 24;    // idle share of each side, in percent

  localparam longint SMP_HI = (64'sd1 <<< (sfd_pkg::SAMPLE_W - 1)) - 64'sd1;
  localparam longint SMP_LO = -SMP_HI - 64'sd1;

  typedef logic signed [sfd_pkg::SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    silent;
    logic    last;
  } stereo_beat_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    block_end;
  } echo_out_t;

  // directed table rows: plain beat, beat with a hand-typed result, register write
  typedef enum logic [1:0] {ROW_BEAT, ROW_PINNED, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e                     kind;
    logic [sfd_pkg::IDX_W-1:0]     idx;
    logic [sfd_pkg::CFG_W-1:0]     wdata;
    stereo_beat_t                  beat;
    echo_out_t                     want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                      cfg_we_i    = 1'b0;
  logic [sfd_pkg::IDX_W-1:0] cfg_idx_i   = sfd_pkg::CFG_ENABLE;
  logic [sfd_pkg::CFG_W-1:0] cfg_wdata_i = '0;

  logic         in_valid_i = 1'b0;
  stereo_beat_t beat_drv   = '0;
  logic         pin_now    = 1'b0;  // current beat carries a typed result
  echo_out_t    pin_val    = '0;

  logic    in_ready_o;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  sample_t left_out_o;
  sample_t right_out_o;
  logic    block_end_o;

  // test-flow knobs, written only by the main sequence
  bit calm    = 1'b0;  // no idling on either side
  bit hold_go = 1'b0;  // arm the long receiver hold-off

  int        hold_cnt = 0;
  int        quiet_cycles = 0;
  int        errors = 0;
  echo_out_t echo_due[$];   // results still owed by the core, oldest first
  echo_out_t predicted;
  echo_out_t due;

  // predictor state: own copy of registers, store and position
  logic                         m_enable;
  logic [sfd_pkg::GAIN_W-1:0]   m_gain;
  logic [sfd_pkg::LEN_W-1:0]    m_length;
  int                           m_wpos;
  sample_t                      echo_l [int];  // slots never written read as zero
  sample_t                      echo_r [int];

  always #5 clk_i = ~clk_i;

  stereo_feedback_delay_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .left_in_i       (beat_drv.left),
    .right_in_i      (beat_drv.right),
    .silent_i        (beat_drv.silent),
    .last_in_block_i (beat_drv.last),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .left_out_o      (left_out_o),
    .right_out_o     (right_out_o),
    .block_end_o     (block_end_o)
  );

  // ---------------------------------------------------------------------------
  // Echo predictor
  // ---------------------------------------------------------------------------

  // Q1.16 gain, round to nearest with ties up: floor((v*g + 2^15) / 2^16)
  function automatic longint gain_scale(longint v);
    longint p;
    p = v * longint'(m_gain) + (64'sd1 <<< (sfd_pkg::GAIN_FRAC - 1));
    return p >>> sfd_pkg::GAIN_FRAC;
  endfunction

  function automatic sample_t clip(longint v);
    if (v > SMP_HI) begin
      return sample_t'(SMP_HI);
    end else if (v < SMP_LO) begin
      return sample_t'(SMP_LO);
    end
    return sample_t'(v);
  endfunction

  function automatic void wipe_store();
    echo_l.delete();
    echo_r.delete();
    m_wpos = 0;
  endfunction

  // Advances the store by one beat when enabled and returns the result it yields.
  function automatic echo_out_t echo_predict(stereo_beat_t b);
    echo_out_t o;
    int        len;
    int        pos;
    int        nxt;
    longint    add_l;
    longint    add_r;
    longint    old_l;
    longint    old_r;
    o.block_end = b.last;
    if (!m_enable) begin
      // bypass: nothing moves
      o.left  = b.left;
      o.right = b.right;
      return o;
    end
    // zero length behaves as one, anything past the store as the full store
    len = int'(m_length);
    if (len < 1) len = 1;
    if (len > sfd_pkg::MAX_DELAY) len = sfd_pkg::MAX_DELAY;
    pos = m_wpos;
    if (pos >= len) pos = 0;
    add_l = b.silent ? 64'sd0 : longint'(b.left);
    add_r = b.silent ? 64'sd0 : longint'(b.right);
    old_l = echo_l.exists(pos) ? longint'(echo_l[pos]) : 64'sd0;
    old_r = echo_r.exists(pos) ? longint'(echo_r[pos]) : 64'sd0;
    echo_l[pos] = clip(gain_scale(old_l) + add_l);
    echo_r[pos] = clip(gain_scale(old_r) + add_r);
    nxt = pos + 1;
    if (nxt >= len) nxt = 0;
    m_wpos = nxt;
    // with a one-slot delay the tap is the slot just written
    old_l = echo_l.exists(nxt) ? longint'(echo_l[nxt]) : 64'sd0;
    old_r = echo_r.exists(nxt) ? longint'(echo_r[nxt]) : 64'sd0;
    o.left  = clip(longint'(b.left) + gain_scale(old_l));
    o.right = clip(longint'(b.right) + gain_scale(old_r));
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: inputs are predicted as they are taken, outputs checked in order
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(string field, longint want, longint got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      // predictor always runs so its state stays in step with the core
      predicted = echo_predict(beat_drv);
      echo_due.push_back(pin_now ? pin_val : predicted);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (echo_due.size() == 0) begin
        errors++;
        $display("%0t: output beat with nothing expected, actual %0d %0d %0b",
                 $time, left_out_o, right_out_o, block_end_o);
      end else begin
        due = echo_due.pop_front();
        if (left_out_o !== due.left) flag_mismatch("left_out", due.left, left_out_o);
        if (right_out_o !== due.right) flag_mismatch("right_out", due.right, right_out_o);
        if (block_end_o !== due.block_end) begin
          flag_mismatch("block_end", due.block_end, block_end_o);
        end
      end
    end
  end

  // watchdog: trips when no beat and no register write moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, one long hold-off once armed
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_go && hold_cnt < HOLD_CYCLES) begin
      hold_cnt    <= hold_cnt + 1;
      out_ready_i <= 1'b0;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= SLOW_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side; every task is entered and left just after a falling edge
  // ---------------------------------------------------------------------------

  task automatic send_beat(stereo_beat_t b, logic pinned, echo_out_t want);
    while (!calm && $urandom_range(99) < SLOW_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    beat_drv   <= b;
    pin_now    <= pinned;
    pin_val    <= want;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // drop valid and let every owed result come back before touching registers
  task automatic drain();
    in_valid_i <= 1'b0;
    while (echo_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [sfd_pkg::IDX_W-1:0] idx, logic [sfd_pkg::CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      sfd_pkg::CFG_ENABLE: m_enable = data[0];
      sfd_pkg::CFG_GAIN:   m_gain = data[sfd_pkg::GAIN_W-1:0];
      sfd_pkg::CFG_LENGTH: begin
        m_length = data[sfd_pkg::LEN_W-1:0];
        wipe_store();
      end
      default: ;  // unmapped index, no effect
    endcase
    // wait for another falling edge so a following write starts in a later time step
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table helpers and random sample source
  // ---------------------------------------------------------------------------

  function automatic row_t beat_row(sample_t l, sample_t r, logic s, logic e);
    row_t w;
    w      = '0;
    w.kind = ROW_BEAT;
    w.beat = '{l, r, s, e};
    return w;
  endfunction

  function automatic row_t pinned_row(sample_t l, sample_t r, logic s, logic e,
                                      sample_t want_l, sample_t want_r, logic want_e);
    row_t w;
    w      = beat_row(l, r, s, e);
    w.kind = ROW_PINNED;
    w.want = '{want_l, want_r, want_e};
    return w;
  endfunction

  function automatic row_t write_row(logic [sfd_pkg::IDX_W-1:0] idx,
                                     logic [sfd_pkg::CFG_W-1:0] data);
    row_t w;
    w       = '0;
    w.kind  = ROW_WRITE;
    w.idx   = idx;
    w.wdata = data;
    return w;
  endfunction

  // full-scale noise mostly, with rails and quiet material mixed in
  function automatic sample_t pick_sample();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) begin
      return $urandom_range(1) ? sample_t'(SMP_HI) : sample_t'(SMP_LO);
    end else if (sel < 3) begin
      return sample_t'(int'($urandom_range(2000)) - 1000);
    end
    return sample_t'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    row_t                        plan[$];
    stereo_beat_t                b;
    logic [sfd_pkg::GAIN_W-1:0]  g;
    logic [sfd_pkg::LEN_W-1:0]   len;
    int                          sel;

    m_enable = 1'b0;
    m_gain   = sfd_pkg::GAIN_RESET;
    m_length = sfd_pkg::LEN_W'(12000);
    wipe_store();

    // bypass after reset: beats come back untouched
    plan.push_back(pinned_row(8388607, -8388608, 0, 1, 8388607, -8388608, 1));
    plan.push_back(pinned_row(-8388608, 8388607, 1, 0, -8388608, 8388607, 0));
    plan.push_back(pinned_row(0, -1, 1, 1, 0, -1, 1));
    // unmapped index with every data bit set: must not enable anything
    plan.push_back(write_row(CFG_SPARE, '1));
    plan.push_back(pinned_row(123456, -654321, 0, 0, 123456, -654321, 0));
    // echo on with reset gain and length; store is empty so output = input
    plan.push_back(write_row(sfd_pkg::CFG_ENABLE, 1));
    plan.push_back(pinned_row(1000, -1000, 0, 1, 1000, -1000, 1));
    plan.push_back(beat_row(2000, 3000, 0, 0));
    // one-slot delay at unity gain: tap is the slot just written
    plan.push_back(write_row(sfd_pkg::CFG_LENGTH, 1));
    plan.push_back(write_row(sfd_pkg::CFG_GAIN, 65536));
    plan.push_back(beat_row(100, -100, 0, 0));
    plan.push_back(pinned_row(8388607, -8388608, 0, 1, 8388607, -8388608, 1));
    plan.push_back(beat_row(5, 5, 1, 0));
    plan.push_back(beat_row(0, 0, 1, 1));
    // zero length behaves as one
    plan.push_back(write_row(sfd_pkg::CFG_LENGTH, 0));
    plan.push_back(beat_row(4000000, -4000000, 0, 0));
    plan.push_back(beat_row(4000000, -4000000, 0, 1));
    // zero gain: echo contributes nothing
    plan.push_back(write_row(sfd_pkg::CFG_GAIN, 0));
    plan.push_back(pinned_row(777, -777, 0, 0, 777, -777, 0));
    // gain above one, saturation bounds the store
    plan.push_back(write_row(sfd_pkg::CFG_GAIN, 131071));
    plan.push_back(write_row(sfd_pkg::CFG_LENGTH, 3));
    plan.push_back(beat_row(8388607, 8388607, 0, 0));
    plan.push_back(beat_row(-8388608, -8388608, 0, 1));
    plan.push_back(beat_row(1, -1, 0, 0));
    plan.push_back(beat_row(0, 0, 1, 0));
    // disabled mid-stream: pass through, store frozen
    plan.push_back(write_row(sfd_pkg::CFG_ENABLE, 0));
    plan.push_back(pinned_row(-5, 5, 1, 1, -5, 5, 1));
    plan.push_back(write_row(sfd_pkg::CFG_ENABLE, 1));
    plan.push_back(beat_row(10, 20, 0, 0));
    // over-long length clamps to the full store, then the full store itself
    plan.push_back(write_row(sfd_pkg::CFG_LENGTH, '1));
    plan.push_back(write_row(sfd_pkg::CFG_GAIN, 32768));
    plan.push_back(beat_row(8388607, -8388608, 0, 0));
    plan.push_back(beat_row(-1, 1, 0, 1));
    plan.push_back(write_row(sfd_pkg::CFG_LENGTH, 262144));
    plan.push_back(beat_row(12345, -12345, 0, 0));
    // only bit 0 of the enable write counts
    plan.push_back(write_row(sfd_pkg::CFG_ENABLE, 19'h7FFFE));
    plan.push_back(pinned_row(42, -42, 0, 1, 42, -42, 1));

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain();
        write_reg(plan[i].idx, plan[i].wdata);
      end else begin
        send_beat(plan[i].beat, plan[i].kind == ROW_PINNED, plan[i].want);
      end
    end
    drain();

    // random phases; each one starts from a fresh gain and enable, and mostly a fresh length, written while idle
    for (int ph = 0; ph < N_PHASES; ph++) begin
      // length: mostly short so the store wraps often, now and then huge
      if (ph == 0 || $urandom_range(3) != 0) begin
        sel = $urandom_range(9);
        case (sel)
          0:       len = sfd_pkg::LEN_W'($urandom_range(1, 3));
          6:       len = sfd_pkg::LEN_W'($urandom_range(65, 400));
          7:       len = sfd_pkg::LEN_W'($urandom);
          8:       len = '0;
          9:       len = sfd_pkg::LEN_W'(1);
          default: len = sfd_pkg::LEN_W'($urandom_range(2, 64));
        endcase
        write_reg(sfd_pkg::CFG_LENGTH, len);
      end
      sel = $urandom_range(7);
      case (sel)
        0:       g = '0;
        1:       g = sfd_pkg::GAIN_W'(65536);
        2:       g = sfd_pkg::GAIN_W'($urandom_range(65537, 131071));
        3:       g = sfd_pkg::GAIN_W'(65535);
        default: g = sfd_pkg::GAIN_W'($urandom_range(0, 65536));
      endcase
      // spare high data bits carry noise; the core must ignore them
      write_reg(sfd_pkg::CFG_GAIN, {2'($urandom_range(3)), g});
      write_reg(sfd_pkg::CFG_ENABLE, {18'($urandom), (ph != 5)});

      calm = (ph == 4);       // one stretch with no idling at all
      if (ph == 2) hold_go = 1'b1;  // long receiver hold-off, input backs up

      for (int k = 0; k < PHASE_BEATS; k++) begin
        b.left   = pick_sample();
        b.right  = pick_sample();
        b.silent = ($urandom_range(3) == 0);
        b.last   = ($urandom_range(7) == 0);
        send_beat(b, 1'b0, '0);
      end
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
